// ----- sv/mexp_pkg.sv -----
`default_nettype none

package mexp_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned CntW  = $clog2(Width);

  typedef logic [Width-1:0] word_t;

  typedef struct packed {
    word_t base;
    word_t exponent;
  } mexp_in_t;

  typedef struct packed {
    word_t residue;
    logic  error;
  } mexp_out_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqReduce,
    SeqSquare,
    SeqMult,
    SeqDone
  } seq_state_e;

endpackage

`default_nettype wire

// ----- sv/mexp_mulmod.sv -----
`default_nettype none

// Bit-serial (a * b) mod m: one bit of b per cycle, MSB first.
// Each step forms 2*acc + bit*a (< 3m) and subtracts 0, m or 2m.
// Also used with a = 1 to reduce b modulo m.
module mexp_mulmod import mexp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  input  wire word_t    modulus_i,
  output mul_rsp_t      rsp_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  word_t           acc_q, acc_d;
  word_t           a_q, a_d;
  word_t           b_q, b_d;

  logic [Width+1:0] sum, diff1, diff2, mod1, mod2;
  word_t            step;

  always_comb begin
    mod1  = {2'b00, modulus_i};
    mod2  = {1'b0, modulus_i, 1'b0};
    sum   = {1'b0, acc_q, 1'b0} + (b_q[Width-1] ? {2'b00, a_q} : '0);
    diff1 = sum - mod1;
    diff2 = sum - mod2;
    if (!diff2[Width+1]) begin
      step = diff2[Width-1:0];
    end else if (!diff1[Width+1]) begin
      step = diff1[Width-1:0];
    end else begin
      step = sum[Width-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Width - 1);
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
    end else if (busy_q) begin
      acc_d = step;
      b_d   = {b_q[Width-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

// ----- sv/mexp_seq.sv -----
`default_nettype none

// Square-and-multiply sequencer: reduces the base, then walks the
// exponent MSB first, issuing one product at a time to the multiplier.
module mexp_seq import mexp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire mexp_in_t in_i,
  input  wire word_t    modulus_i,
  output mul_req_t      mul_req_o,
  input  wire mul_rsp_t mul_rsp_i,
  output logic          result_valid_o,
  output mexp_out_t     result_o
);

  seq_state_e      state_q, state_d;
  word_t           base_q, base_d;
  word_t           exp_q, exp_d;
  word_t           r_q, r_d;
  logic            err_q, err_d;
  logic [CntW-1:0] bit_q, bit_d;

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    exp_d     = exp_q;
    r_d       = r_q;
    err_d     = err_q;
    bit_d     = bit_q;
    mul_req_o = '0;
    case (state_q)
      SeqIdle: begin
        if (start) begin
          if (modulus_i == '0) begin
            r_d     = '0;
            err_d   = 1'b1;
            state_d = SeqDone;
          end else begin
            err_d           = 1'b0;
            exp_d           = in_i.exponent;
            bit_d           = CntW'(Width - 1);
            r_d             = (modulus_i == word_t'(1)) ? '0 : word_t'(1);
            mul_req_o.start = 1'b1;
            mul_req_o.a     = word_t'(1);
            mul_req_o.b     = in_i.base;
            state_d         = SeqReduce;
          end
        end
      end
      SeqReduce: begin
        if (mul_rsp_i.done) begin
          base_d          = mul_rsp_i.prod;
          mul_req_o.start = 1'b1;
          mul_req_o.a     = r_q;
          mul_req_o.b     = r_q;
          state_d         = SeqSquare;
        end
      end
      SeqSquare: begin
        if (mul_rsp_i.done) begin
          r_d = mul_rsp_i.prod;
          if (exp_q[Width-1]) begin
            mul_req_o.start = 1'b1;
            mul_req_o.a     = mul_rsp_i.prod;
            mul_req_o.b     = base_q;
            state_d         = SeqMult;
          end else if (bit_q == '0) begin
            state_d = SeqDone;
          end else begin
            bit_d           = bit_q - CntW'(1);
            exp_d           = {exp_q[Width-2:0], 1'b0};
            mul_req_o.start = 1'b1;
            mul_req_o.a     = mul_rsp_i.prod;
            mul_req_o.b     = mul_rsp_i.prod;
          end
        end
      end
      SeqMult: begin
        if (mul_rsp_i.done) begin
          r_d = mul_rsp_i.prod;
          if (bit_q == '0) begin
            state_d = SeqDone;
          end else begin
            bit_d           = bit_q - CntW'(1);
            exp_d           = {exp_q[Width-2:0], 1'b0};
            mul_req_o.start = 1'b1;
            mul_req_o.a     = mul_rsp_i.prod;
            mul_req_o.b     = mul_rsp_i.prod;
            state_d         = SeqSquare;
          end
        end
      end
      SeqDone: begin
        state_d = SeqIdle;
      end
      default: begin
        state_d = SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    r_q    <= r_d;
    err_q  <= err_d;
  end

  assign busy             = (state_q != SeqIdle);
  assign result_valid_o   = (state_q == SeqDone);
  assign result_o.residue = r_q;
  assign result_o.error   = err_q;

endmodule

`default_nettype wire

// ----- sv/modular_exponentiation.sv -----
// Modular exponentiation, base ** exponent mod modulus, by square-and-multiply
// over all 32 exponent bits, MSB first. One word goes in while busy is low;
// its result shows on result_o for exactly one cycle with result_valid_o and
// cannot be held off, so the receiver must take it then. Every modular product
// runs through one shared bit-serial multiplier, one multiplier bit per cycle.
// A zero modulus returns error with residue 0. The modulus register resets to
// 1; the user must write it only while idle, as the block itself does not
// enforce this.
`default_nettype none

module modular_exponentiation import mexp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire word_t    cfg_wdata_i,
  input  wire logic     start,
  output logic          busy,
  input  wire mexp_in_t in_i,
  output logic          result_valid_o,
  output mexp_out_t     result_o
);

  word_t    modulus_q;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= word_t'(1);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  mexp_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .modulus_i      (modulus_q),
    .mul_req_o      (mul_req),
    .mul_rsp_i      (mul_rsp),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .modulus_i (modulus_q),
    .rsp_o     (mul_rsp)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mexp_pkg::*;

  typedef struct packed {
    bit        wr;        // load modulus before this word
    word_t     modulus;
    word_t     base;
    word_t     exponent;
    bit        known;     // residue/error typed in below
    word_t     residue;
    bit        error;
  } dir_row_t;

  localparam int NumDir   = 19;
  localparam int NumRand  = 290;
  localparam int NumPhase = 10;
  localparam int DrainCyc = 2200;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  word_t     cfg_wdata_i;
  logic      start;
  logic      busy;
  mexp_in_t  in_word;
  logic      result_valid_o;
  mexp_out_t result_word;

  mexp_out_t residues_due [$];
  word_t     modulus;
  int        mismatches;

  dir_row_t dir_rows [NumDir] = '{
    // reset modulus is 1: everything reduces to 0
    '{1'b0, 32'h0000_0000, 32'h0000_0005, 32'h0000_0003, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    // zero modulus flags error
    '{1'b1, 32'h0000_0000, 32'h0000_0007, 32'h0000_0009, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
    '{1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'h0000_0001, 1'b0},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h0000_0002, 32'h0000_001F, 1'b1, 32'h8000_0000, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h0000_0002, 32'h0000_0020, 1'b1, 32'h0000_0001, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h1234_5678, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b1, 32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},
    '{1'b0, 32'h0000_0000, 32'h0000_0002, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
    // largest 32-bit prime: Fermat gives 1
    '{1'b1, 32'hFFFF_FFFB, 32'h0000_0003, 32'hFFFF_FFFA, 1'b1, 32'h0000_0001, 1'b0},
    '{1'b0, 32'h0000_0000, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0004, 1'b0},
    '{1'b1, 32'h8000_0000, 32'h0000_0003, 32'h5555_5555, 1'b0, 32'h0000_0000, 1'b0},
    '{1'b0, 32'h0000_0000, 32'hAAAA_AAAA, 32'h0000_0001, 1'b1, 32'h2AAA_AAAA, 1'b0}
  };

  modular_exponentiation DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .in_i          (in_word),
    .result_valid_o(result_valid_o),
    .result_o      (result_word)
  );

  always #2 clk_i = ~clk_i;

  // square-and-multiply, MSB first, exact double-width products
  function automatic mexp_out_t power_mod(word_t b, word_t e, word_t m);
    mexp_out_t r;
    logic [2*Width-1:0] acc;
    logic [2*Width-1:0] bb;
    logic [2*Width-1:0] mm;
    r.residue = '0;
    r.error   = (m == '0);
    if (m != '0) begin
      mm  = {{Width{1'b0}}, m};
      bb  = {{Width{1'b0}}, b} % mm;
      acc = 1 % mm;
      for (int i = Width - 1; i >= 0; i--) begin
        acc = (acc * acc) % mm;
        if (e[i]) acc = (acc * bb) % mm;
      end
      r.residue = acc[Width-1:0];
    end
    return r;
  endfunction

  function automatic word_t pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'($urandom_range(0, 15));
      3: return word_t'(1) << $urandom_range(0, Width - 1);
      default: return word_t'($urandom);
    endcase
  endfunction

  // start stays high between back-to-back words
  task automatic send_word(input word_t b, input word_t e, input bit known,
                           input mexp_out_t typed);
    int        gap;
    mexp_out_t due;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    in_word.base     <= b;
    in_word.exponent <= e;
    do @(posedge clk_i); while (busy);
    due = known ? typed : power_mod(b, e, modulus);
    residues_due = {residues_due, due};
  endtask

  task automatic load_modulus(input word_t m);
    start <= 1'b0;
    while (residues_due.size() != 0 || busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    modulus = m;
  endtask

  always @(posedge clk_i) begin
    mexp_out_t want;
    if (rst_ni && result_valid_o) begin
      if (residues_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got residue %h error %b",
                 $time, result_word.residue, result_word.error);
      end else begin
        want = residues_due.pop_front();
        if (result_word.residue !== want.residue) begin
          mismatches++;
          $display("%0t: residue expected %h, got %h", $time, want.residue,
                   result_word.residue);
        end
        if (result_word.error !== want.error) begin
          mismatches++;
          $display("%0t: error expected %b, got %b", $time, want.error,
                   result_word.error);
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    mexp_out_t typed;
    word_t     m;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start       = 1'b0;
    in_word     = '0;
    modulus     = 32'd1;
    mismatches  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) load_modulus(dir_rows[i].modulus);
      typed.residue = dir_rows[i].residue;
      typed.error   = dir_rows[i].error;
      send_word(dir_rows[i].base, dir_rows[i].exponent, dir_rows[i].known, typed);
    end

    for (int ph = 0; ph < NumPhase; ph++) begin
      case (ph)
        1:       m = word_t'($urandom_range(2, 255));
        2:       m = '0;
        3:       m = '1;
        4:       m = word_t'($urandom) | (word_t'(1) << (Width - 1));
        5:       m = word_t'(1);
        7:       m = word_t'($urandom_range(2, 15));
        8:       m = word_t'($urandom) & 32'h0000_FFFF;
        default: m = word_t'($urandom);
      endcase
      load_modulus(m);
      for (int n = 0; n < NumRand / NumPhase; n++)
        send_word(pick_operand(), pick_operand(), 1'b0, '0);
    end

    start <= 1'b0;
    while (residues_due.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
